/* hdl/bcbs_pkg.sv */
// ----------------------------------------------------------------------------
// bcbs_pkg
// Shared types, codes and reset values of the binary clock with button set.
// ----------------------------------------------------------------------------
package bcbs_pkg;

    localparam int CfgIdxW   = 8;
    localparam int ThreshW   = 16;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 32;

    localparam logic [CfgIdxW-1:0] CFG_SHORT_MIN = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_MIN  = 8'd1;

    localparam logic [ThreshW-1:0] SHORT_MIN_RST = 16'd10;
    localparam logic [ThreshW-1:0] LONG_MIN_RST  = 16'd5000;
    localparam logic [ThreshW-1:0] PRESS_MAX     = 16'hFFFF;

    localparam logic [1:0] FIELD_HOURS   = 2'd0;
    localparam logic [1:0] FIELD_MINUTES = 2'd1;
    localparam logic [1:0] FIELD_SECONDS = 2'd2;
    localparam logic [1:0] FIELD_PAST    = 2'd3;

    localparam logic [5:0] SEC_RST   = 6'd5;
    localparam logic [5:0] MIN_RST   = 6'd5;
    localparam logic [5:0] HOUR_RST  = 6'd17;
    localparam logic [5:0] WRAP_60   = 6'd60;
    localparam logic [3:0] HOUR_WRAP = 4'd13;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [5:0] hour;
        logic [1:0] field;
        logic       edit;
    } clk_state_t;

    typedef struct packed {
        logic [1:0] day_half;
        logic [3:0] hour_now;
        logic [5:0] minutes_now;
        logic [5:0] seconds_now;
        logic       edit_mode;
        logic [1:0] shown_field;
        logic [5:0] shown_value;
    } result_t;

    function automatic clk_state_t settle(input clk_state_t st);
        clk_state_t r;
        r = st;
        if (r.sec == WRAP_60) begin
            r.sec = '0;
            r.min = r.min + 6'd1;
        end
        if (r.min == WRAP_60) begin
            r.min  = '0;
            r.hour = r.hour + 6'd1;
        end
        if (r.hour[3:0] == HOUR_WRAP) begin
            r.hour = {~r.hour[5:4], 4'd1};
        end
        if (r.field == FIELD_PAST) begin
            r.field = FIELD_HOURS;
            r.edit  = 1'b0;
        end
        return r;
    endfunction

endpackage

/* hdl/bcbs_core.sv */
// ----------------------------------------------------------------------------
// bcbs_core
// Time and setter state with its single-pass next-state logic.
// ----------------------------------------------------------------------------
module bcbs_core
    import bcbs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic               second_tick,
    input  logic               button_down,
    input  logic [ThreshW-1:0] short_min,
    input  logic [ThreshW-1:0] long_min,
    output result_t            result_next
);

    clk_state_t         state_reg, state_next;
    logic [ThreshW-1:0] press_reg, press_next;
    logic               was_down_reg;

    always_comb begin
        clk_state_t st;
        logic       short_hit;
        logic       long_hit;
        st         = state_reg;
        press_next = press_reg;
        short_hit  = (press_reg > short_min) && (press_reg < long_min);
        long_hit   = (press_reg > long_min);

        if (second_tick) begin
            st.sec = st.sec + 6'd1;
            st     = settle(st);
        end

        if (button_down) begin
            if (press_reg != PRESS_MAX) begin
                press_next = press_reg + 16'd1;
            end
        end else if (was_down_reg) begin
            if (short_hit) begin
                if (st.edit) begin
                    case (st.field)
                        FIELD_HOURS:   st.hour = st.hour + 6'd1;
                        FIELD_MINUTES: st.min  = st.min + 6'd1;
                        FIELD_SECONDS: st.sec  = st.sec + 6'd1;
                        default:       ;
                    endcase
                end else begin
                    st.field = st.field + 2'd1;
                end
            end
            if (long_hit) begin
                if (st.edit) begin
                    st.field = st.field + 2'd1;
                end else begin
                    st.edit  = 1'b1;
                    st.field = FIELD_HOURS;
                end
            end
            press_next = '0;
        end

        state_next = settle(st);

        case (state_next.field)
            FIELD_HOURS:   result_next.shown_value = state_next.hour;
            FIELD_MINUTES: result_next.shown_value = state_next.min;
            default:       result_next.shown_value = state_next.sec;
        endcase
        result_next.shown_field = state_next.field;
        result_next.edit_mode   = state_next.edit;
        result_next.seconds_now = state_next.sec;
        result_next.minutes_now = state_next.min;
        result_next.hour_now    = state_next.hour[3:0];
        result_next.day_half    = state_next.hour[5:4];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.sec   <= SEC_RST;
            state_reg.min   <= MIN_RST;
            state_reg.hour  <= HOUR_RST;
            state_reg.field <= FIELD_SECONDS;
            state_reg.edit  <= 1'b0;
            press_reg       <= '0;
            was_down_reg    <= 1'b0;
        end else if (step_en) begin
            state_reg    <= state_next;
            press_reg    <= press_next;
            was_down_reg <= button_down;
        end
    end

endmodule

/* hdl/binary_clock_with_button_set.sv */
// An accepted item is held in the input register; its result item is then registered in the result register.
// Throughput: one item per cycle; input register and result register advance
// together whenever the result slot is empty or being taken.
// Reset: synchronous, active low; time 1:05:05 day-half 1, seconds shown,
// edit mode off, thresholds 10 and 5000, both channels empty.
// ----------------------------------------------------------------------------
// binary_clock_with_button_set
// Twelve-hour binary clock with a one-button setter, one sample tick per item.
// ----------------------------------------------------------------------------
module binary_clock_with_button_set
    import bcbs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // second_tick, button_down
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // shown_value, shown_field, edit_mode,
                                           // seconds_now, minutes_now, hour_now,
                                           // day_half
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [ThreshW-1:0]  cfg_data
);

    logic               in_valid_reg;
    logic               tick_reg;
    logic               down_reg;
    logic               out_valid_reg;
    result_t            result_reg;
    result_t            result_next;
    logic [ThreshW-1:0] short_min_reg;
    logic [ThreshW-1:0] long_min_reg;
    logic               advance;
    logic               step_en;

    assign advance   = !out_valid_reg || m_tready;
    assign step_en   = advance && in_valid_reg;
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(OutDataW - $bits(result_t)){1'b0}}, result_reg};

    bcbs_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (step_en),
        .second_tick (tick_reg),
        .button_down (down_reg),
        .short_min   (short_min_reg),
        .long_min    (long_min_reg),
        .result_next (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            short_min_reg <= SHORT_MIN_RST;
            long_min_reg  <= LONG_MIN_RST;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SHORT_MIN: short_min_reg <= cfg_data;
                    CFG_LONG_MIN:  long_min_reg  <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            tick_reg <= s_tdata[0];
            down_reg <= s_tdata[1];
        end
        if (step_en) begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_field_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:6] != FIELD_PAST))
        else $error("result item shows field past seconds");

    a_hour_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:21] != 4'd0) && (m_tdata[24:21] != HOUR_WRAP))
        else $error("result item hour out of range");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_valid_reg) |=> out_valid_reg)
        else $error("held item not moved to result register");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result channel not empty after reset");
`endif

endmodule

/* tb/binary_clock_with_button_set_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_clock_with_button_set_test
// Self-checking bench for the binary clock with button set. Sample ticks are
// driven as button presses of chosen lengths around the press thresholds,
// bursts of second pulses and random noise. A clock tracker follows the time,
// the selected field and edit mode, and checks every result item in order.
// Both channels idle at random. Thresholds are changed between phases.
// ----------------------------------------------------------------------------
module binary_clock_with_button_set_test;
    import bcbs_pkg::*;

    class clock_tracker;
        logic [ThreshW-1:0] short_min;
        logic [ThreshW-1:0] long_min;
        logic [5:0]         secs;
        logic [5:0]         mins;
        logic [5:0]         hours;
        logic [1:0]         field;
        logic               edit;
        logic [ThreshW-1:0] held;
        logic               was_down;
        result_t            due_readings[$];
        int                 mismatches;

        function new();
            short_min  = SHORT_MIN_RST;
            long_min   = LONG_MIN_RST;
            secs       = SEC_RST;
            mins       = MIN_RST;
            hours      = HOUR_RST;
            field      = FIELD_SECONDS;
            edit       = 1'b0;
            held       = '0;
            was_down   = 1'b0;
            mismatches = 0;
        endfunction

        function void set_threshold(input logic [CfgIdxW-1:0] idx,
                                    input logic [ThreshW-1:0] val);
            if (idx == CFG_SHORT_MIN) begin
                short_min = val;
            end else if (idx == CFG_LONG_MIN) begin
                long_min = val;
            end
        endfunction

        function int pending();
            return due_readings.size();
        endfunction

        function void carry_time();
            if (secs == WRAP_60) begin
                secs = '0;
                mins = mins + 6'd1;
            end
            if (mins == WRAP_60) begin
                mins  = '0;
                hours = hours + 6'd1;
            end
            if (hours[3:0] == HOUR_WRAP) begin
                hours = {~hours[5:4], 4'd1};
            end
            if (field == FIELD_PAST) begin
                field = FIELD_HOURS;
                edit  = 1'b0;
            end
        endfunction

        function void judge_press(input logic [ThreshW-1:0] len);
            if (len > short_min && len < long_min) begin
                if (!edit) begin
                    field = field + 2'd1;
                end else if (field == FIELD_HOURS) begin
                    hours = hours + 6'd1;
                end else if (field == FIELD_MINUTES) begin
                    mins = mins + 6'd1;
                end else if (field == FIELD_SECONDS) begin
                    secs = secs + 6'd1;
                end
            end
            if (len > long_min) begin
                if (edit) begin
                    field = field + 2'd1;
                end else begin
                    edit  = 1'b1;
                    field = FIELD_HOURS;
                end
            end
        endfunction

        function void take_sample(input bit tick, input bit down);
            result_t r;
            if (tick) begin
                secs = secs + 6'd1;
                carry_time();
            end
            if (down) begin
                if (held != PRESS_MAX) held = held + 16'd1;
            end else if (was_down) begin
                judge_press(held);
                held = '0;
            end
            was_down = down;
            carry_time();
            r = '0;
            r.shown_value = (field == FIELD_HOURS)   ? hours :
                            (field == FIELD_MINUTES) ? mins : secs;
            r.shown_field = field;
            r.edit_mode   = edit;
            r.seconds_now = secs;
            r.minutes_now = mins;
            r.hour_now    = hours[3:0];
            r.day_half    = hours[5:4];
            due_readings.push_back(r);
        endfunction

        function void fault(input string msg);
            mismatches++;
            $error("%s", msg);
        endfunction

        function void compare(input string name, input logic [7:0] want,
                              input logic [7:0] got);
            if (got !== want) fault($sformatf("%s: expected %0d, got %0d", name, want, got));
        endfunction

        function void check_reading(input result_t got);
            result_t want;
            if (due_readings.size() == 0) begin
                fault("result item with none expected");
                return;
            end
            want = due_readings.pop_front();
            compare("shown_value", want.shown_value, got.shown_value);
            compare("shown_field", want.shown_field, got.shown_field);
            compare("edit_mode",   want.edit_mode,   got.edit_mode);
            compare("seconds_now", want.seconds_now, got.seconds_now);
            compare("minutes_now", want.minutes_now, got.minutes_now);
            compare("hour_now",    want.hour_now,    got.hour_now);
            compare("day_half",    want.day_half,    got.day_half);
        endfunction
    endclass

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;   // second_tick, button_down
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;          // shown_value, shown_field, edit_mode,
                                           // seconds_now, minutes_now, hour_now,
                                           // day_half
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [ThreshW-1:0]  cfg_data  = '0;

    clock_tracker tracker = new();
    bit           quiet   = 1'b0;
    int           sent    = 0;
    int           phase_short[7] = '{2, 0, 3, 5, 9, 0, 1};
    int           phase_long[7]  = '{6, 1, 12, 5, 4, 0, 3};

    binary_clock_with_button_set DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_sample(input bit tick, input bit down);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(InDataW-2){1'b0}}, down, tick};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.take_sample(tick, down);
        sent++;
    endtask

    // len ticks held, then one release tick
    task automatic press(input int len, input int tick_pct);
        repeat (len) send_sample($urandom_range(0, 99) < tick_pct, 1'b1);
        send_sample($urandom_range(0, 99) < tick_pct, 1'b0);
    endtask

    task automatic set_thresholds(input logic [ThreshW-1:0] lo,
                                  input logic [ThreshW-1:0] hi);
        logic [CfgIdxW-1:0] idx;
        logic [ThreshW-1:0] val;
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        for (int k = 0; k < 2; k++) begin
            idx = (k == 0) ? CFG_SHORT_MIN : CFG_LONG_MIN;
            val = (k == 0) ? lo : hi;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            tracker.set_threshold(idx, val);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_run(input int n, input int lo, input int hi);
        int stop;
        int len;
        stop = sent + n;
        while (sent < stop) begin
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 40)) send_sample(1'b1, 1'b0);
                1: repeat ($urandom_range(1, 10))
                       send_sample($urandom_range(0, 1), $urandom_range(0, 1));
                default: begin
                    case ($urandom_range(0, 5))
                        0:       len = lo;
                        1:       len = lo + 1;
                        2:       len = hi;
                        3:       len = hi + 1;
                        4:       len = $urandom_range(1, hi + 2);
                        default: len = hi + $urandom_range(1, 4);
                    endcase
                    if (len < 1) len = 1;
                    press(len, 50);
                    repeat ($urandom_range(0, 2)) send_sample($urandom_range(0, 1), 1'b0);
                end
            endcase
        end
    endtask

    initial begin
        int stall;
        result_t got;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = m_tdata[$bits(result_t)-1:0];
                tracker.check_reading(got);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall = pick_gap();
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset thresholds: a short press steps from seconds past the end to hours
        send_sample(1'b1, 1'b0);
        press(11, 0);

        set_thresholds(16'd0, 16'd2);
        press(3, 30);   // long: edit on hours
        press(1, 30);   // short: hour up
        press(2, 0);    // exactly the long threshold: ignored
        press(3, 30);   // edit minutes
        press(3, 30);   // edit seconds
        press(1, 30);
        press(3, 30);   // past seconds: back to hours, edit off

        for (int p = 0; p < 7; p++) begin
            set_thresholds(16'(phase_short[p]), 16'(phase_long[p]));
            quiet = ($urandom_range(0, 3) == 0);
            random_run(75, phase_short[p], phase_long[p]);
        end
        quiet = 1'b0;

        s_tvalid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (tracker.mismatches == 0) begin
            $display("PASS binary_clock_with_button_set");
        end else begin
            $display("FAIL binary_clock_with_button_set");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL binary_clock_with_button_set");
        $finish;
    end

endmodule

/* filelist.f */
hdl/bcbs_pkg.sv
hdl/bcbs_core.sv
hdl/binary_clock_with_button_set.sv
tb/binary_clock_with_button_set_test.sv
